FILE: rtl/assert_macros.svh
// Assertion macros for the executor RTL, included by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication check.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/mtae_pkg.sv
// Types, constants and helpers of the three-address executor.
package mtae_pkg;

    localparam int MEM_WORDS   = 256;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(MEM_WORDS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_RED = 4'd5;
    localparam logic [3:0] OP_WRT = 4'd6;
    localparam logic [3:0] OP_STR = 4'd7;
    localparam logic [3:0] OP_EXP = 4'd9;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_REPORT   = 3'd1;
    localparam logic [2:0] ST_ILLEGAL  = 3'd2;
    localparam logic [2:0] ST_DIVFAULT = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam int BOOT_COUNT = 5;
    localparam logic [DATA_WIDTH-1:0] BOOT_WORDS [BOOT_COUNT] = '{
        DATA_WIDTH'(4), DATA_WIDTH'(23), DATA_WIDTH'(10), DATA_WIDTH'(40), DATA_WIDTH'(5)
    };

    typedef struct packed {
        logic [3:0]        func;
        logic [7:0]        dest_addr;
        logic [7:0]        src_a_addr;
        logic [7:0]        src_b_addr;
        logic signed [31:0] read_value;
    } t_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] report_value;
        logic               report_newline;
    } t_result;

    typedef enum logic [3:0] {
        CL_ADD,
        CL_SUB,
        CL_MUL,
        CL_DIV,
        CL_MOD,
        CL_READ,
        CL_PRINT,
        CL_NOP,
        CL_ILLEGAL,
        CL_IGNORE
    } t_cls;

    typedef struct packed {
        t_cls                  cls;
        logic [7:0]            dest;
        logic [7:0]            src_a;
        logic [7:0]            src_b;
        logic [DATA_WIDTH-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC,
        BS_DIV
    } t_bstate;

    function automatic logic [DATA_WIDTH-1:0] boot_word(input logic [ADDR_W-1:0] idx);
        logic [DATA_WIDTH-1:0] w;
        w = '0;
        if (idx < ADDR_W'(BOOT_COUNT)) begin
            w = BOOT_WORDS[idx[2:0]];
        end
        return w;
    endfunction

endpackage

FILE: rtl/mtae_front.sv
// Front end: accepts instructions, classifies them and tracks the halt flag.
module mtae_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mtae_pkg::t_item i_in_data,
    input  logic            i_q_full,
    input  logic            i_ready,
    output logic            o_push,
    output mtae_pkg::t_cmd  o_push_data
);
    import mtae_pkg::*;

    logic r_halted;
    logic n_halted;
    t_cls cls;

    always_comb begin
        cls = CL_ILLEGAL;
        if (r_halted) begin
            cls = CL_IGNORE;
        end else begin
            unique case (i_in_data.func)
                OP_ADD:  cls = CL_ADD;
                OP_SUB:  cls = CL_SUB;
                OP_MUL:  cls = CL_MUL;
                OP_DIV:  cls = CL_DIV;
                OP_MOD:  cls = CL_MOD;
                OP_RED:  cls = CL_READ;
                OP_STR:  cls = CL_PRINT;
                OP_EXP:  cls = CL_NOP;
                OP_WRT:  cls = CL_ILLEGAL;
                default: cls = CL_ILLEGAL;
            endcase
        end
    end

    assign o_in_stall = i_q_full || !i_ready;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_push_data.cls   = cls;
        o_push_data.dest  = i_in_data.dest_addr;
        o_push_data.src_a = i_in_data.src_a_addr;
        o_push_data.src_b = i_in_data.src_b_addr;
        o_push_data.value = DATA_WIDTH'(i_in_data.read_value);
    end

    // set halt on an illegal opcode, hold until reset
    assign n_halted = r_halted || (o_push && cls == CL_ILLEGAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted <= 1'b0;
        end else begin
            r_halted <= n_halted;
        end
    end

endmodule

FILE: rtl/mtae_queue.sv
// Short command queue between front end and execution back end.
module mtae_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtae_pkg::t_cmd i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output mtae_pkg::t_cmd o_pop_data,
    output logic           o_empty
);
    import mtae_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_ent [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mtae_div.sv
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
module mtae_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mtae_pkg::DATA_WIDTH-1:0] i_dividend,
    input  logic [mtae_pkg::DATA_WIDTH-1:0] i_divisor,
    output mtae_pkg::t_div_stat             o_stat,
    output logic [mtae_pkg::DATA_WIDTH-1:0] o_quo,
    output logic [mtae_pkg::DATA_WIDTH-1:0] o_rem
);
    import mtae_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;
    logic [W:0]       rem_sh;
    logic [W:0]       trial;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ~trial[W]};
            r_rem <= trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

FILE: rtl/mtae_back.sv
// Back end: data memory, boot-time fill, instruction execution and result register.
`include "assert_macros.svh"

module mtae_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtae_pkg::t_cmd    i_q_data,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mtae_pkg::t_result o_out_data
);
    import mtae_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W - 1){1'b0}}};

    logic [W-1:0]      r_mem [MEM_WORDS];
    t_bstate           r_state;
    t_bstate           n_state;
    logic [ADDR_W-1:0] r_clr_idx;
    t_cmd              r_cmd;
    logic [W-1:0]      r_rd_a;
    logic [W-1:0]      r_rd_b;
    logic              r_neg_q;
    logic              r_neg_r;
    logic              r_out_valid;
    t_result           r_out;

    logic              q_pop;
    logic              rd_en;
    logic [ADDR_W-1:0] ra_a;
    logic [ADDR_W-1:0] ra_b;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [W-1:0]      wd;
    logic              res_ld;
    t_result           res;
    logic              div_start;
    logic              out_free;
    logic              div_fault;
    logic              is_div;
    logic [W-1:0]      mag_a;
    logic [W-1:0]      mag_b;
    t_div_stat         div_stat;
    logic [W-1:0]      div_quo;
    logic [W-1:0]      div_rem;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_div    = (r_cmd.cls == CL_DIV) || (r_cmd.cls == CL_MOD);
    assign div_fault = (r_rd_b == '0) || (r_rd_a == WORD_MIN && r_rd_b == '1);
    assign mag_a     = r_rd_a[W-1] ? -r_rd_a : r_rd_a;
    assign mag_b     = r_rd_b[W-1] ? -r_rd_b : r_rd_b;

    mtae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag_a),
        .i_divisor  (mag_b),
        .o_stat     (div_stat),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: begin
                if (r_clr_idx == ADDR_W'(MEM_WORDS - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_q_empty) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                if (is_div && !div_fault) begin
                    n_state = BS_DIV;
                end else if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            BS_DIV: begin
                if (div_stat.done && out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_CLEAR;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        rd_en     = 1'b0;
        ra_a      = (i_q_data.cls == CL_PRINT) ? i_q_data.dest[ADDR_W-1:0]
                                               : i_q_data.src_a[ADDR_W-1:0];
        ra_b      = i_q_data.src_b[ADDR_W-1:0];
        we        = 1'b0;
        wa        = r_cmd.dest[ADDR_W-1:0];
        wd        = '0;
        res_ld    = 1'b0;
        res       = '0;
        div_start = 1'b0;
        unique case (r_state)
            BS_CLEAR: begin
                we = 1'b1;
                wa = r_clr_idx;
                wd = boot_word(r_clr_idx);
            end
            BS_IDLE: begin
                q_pop = !i_q_empty;
                rd_en = !i_q_empty;
            end
            BS_EXEC: begin
                res_ld = out_free;
                unique case (r_cmd.cls)
                    CL_ADD: begin
                        we = out_free;
                        wd = r_rd_a + r_rd_b;
                    end
                    CL_SUB: begin
                        we                 = out_free;
                        wd                 = r_rd_a - r_rd_b;
                        res.status         = ST_REPORT;
                        res.report_value   = 32'(signed'(wd));
                    end
                    CL_MUL: begin
                        we = out_free;
                        wd = W'(r_rd_a * r_rd_b);
                    end
                    CL_DIV, CL_MOD: begin
                        if (div_fault) begin
                            res.status = ST_DIVFAULT;
                        end else begin
                            res_ld    = 1'b0;
                            div_start = 1'b1;
                        end
                    end
                    CL_READ: begin
                        we = out_free;
                        wd = r_cmd.value;
                    end
                    CL_PRINT: begin
                        res.status         = ST_REPORT;
                        res.report_value   = 32'(signed'(r_rd_a));
                        res.report_newline = 1'b1;
                    end
                    CL_NOP: begin
                        res.status = ST_DONE;
                    end
                    CL_ILLEGAL: begin
                        res.status = ST_ILLEGAL;
                    end
                    CL_IGNORE: begin
                        res.status = ST_IGNORED;
                    end
                    default: begin
                        res.status = ST_ILLEGAL;
                    end
                endcase
            end
            BS_DIV: begin
                res_ld = div_stat.done && out_free;
                we     = div_stat.done && out_free;
                if (r_cmd.cls == CL_DIV) begin
                    wd = r_neg_q ? -div_quo : div_quo;
                end else begin
                    wd = r_neg_r ? -div_rem : div_rem;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[ra_a];
            r_rd_b <= r_mem[ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_cmd <= i_q_data;
        end
        if (div_start) begin
            r_neg_q <= r_rd_a[W-1] ^ r_rd_b[W-1];
            r_neg_r <= r_rd_a[W-1];
        end
        if (res_ld) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (res_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_q_pop     = q_pop;
    assign o_ready     = (r_state != BS_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, q_pop, !i_q_empty)
    `ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, div_start, div_stat.busy && r_state == BS_DIV)
    `ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, res_ld, !(r_out_valid && i_out_stall))
    `ASSERT_IMPLY(a_clear_quiet, i_clk, i_rst_n, r_state == BS_CLEAR, !q_pop && !res_ld)

endmodule

FILE: rtl/memory_three_address_alu_executor_top.sv
// Top level of the three-address instruction executor.
//
// Input channel: i_in_valid / o_in_stall carry one instruction (t_item) per
// transfer. Output channel: o_out_valid / i_out_stall carry one result
// (t_result) per instruction, in instruction order.
// After reset the data memory is filled with its boot image, one word per
// cycle, across all 256 words; o_in_stall stays high during that pass and
// the halt flag is cleared.
// Path from transfer to result: queue entry, operand read in the idle state,
// then execution, which loads the result register for add, sub, mul, read,
// print, no-op and error cases; div and mod without a fault first run in
// the radix-2 divider, retiring one quotient bit per cycle over 32 bits.
// The back end runs one instruction at a time.
// A two-entry queue sits behind the front end, so instructions keep being
// taken while a result waits. When the receiver stalls, the result register
// holds and the back end waits; once the queue fills, o_in_stall rises.
module memory_three_address_alu_executor_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mtae_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mtae_pkg::t_result o_out_data
);
    import mtae_pkg::*;

    logic push;
    t_cmd push_data;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_data;
    logic ready;

    mtae_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .i_ready     (ready),
        .o_push      (push),
        .o_push_data (push_data)
    );

    mtae_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_data),
        .o_empty     (q_empty)
    );

    mtae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_data),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
